>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the display command blocks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SSD_ASSERT(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define SSD_ASSERT_NEXT(name, trig, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (expr)) else $error(msg);

`endif

>>> hdl/ssd_pkg.sv
// ---------------------------------------------------------------------------
// ssd_pkg
// Types, constants and segment table for the serial digit display block.
// ---------------------------------------------------------------------------
package ssd_pkg;

    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;
    localparam logic [7:0] CMD_DATA     = 8'h40;
    localparam logic [7:0] CMD_ADDR     = 8'hC0;
    localparam logic [7:0] CMD_CTRL     = 8'h80;

    localparam logic CFG_BRIGHTNESS     = 1'b0;
    localparam logic CFG_DISPLAY_ENABLE = 1'b1;

    localparam logic [2:0] BRIGHTNESS_RESET = 3'h7;
    localparam logic       ENABLE_RESET     = 1'b1;

    localparam logic KIND_ECHO    = 1'b0;
    localparam logic KIND_DISPLAY = 1'b1;

    // Result slots of a display burst.
    localparam logic [2:0] SLOT_ECHO   = 3'd0;
    localparam logic [2:0] SLOT_DATA   = 3'd1;
    localparam logic [2:0] SLOT_ADDR   = 3'd2;
    localparam logic [2:0] SLOT_SEG0   = 3'd3;
    localparam logic [2:0] SLOT_SEG1   = 3'd4;
    localparam logic [2:0] SLOT_SEG2   = 3'd5;
    localparam logic [2:0] SLOT_SEG3   = 3'd6;
    localparam logic [2:0] SLOT_CTRL   = 3'd7;

    typedef struct packed {
        logic [2:0] brightness;
        logic       display_enable;
    } ssd_cfg_t;

    typedef struct packed {
        logic [7:0]      echo;
        logic            burst;
        logic [3:0][3:0] digits;
        logic [7:0]      ctrl;
    } ssd_job_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_stop;
        logic       last;
    } ssd_result_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'b00111111;
            4'd1:    pat = 8'b00000110;
            4'd2:    pat = 8'b01011011;
            4'd3:    pat = 8'b01001111;
            4'd4:    pat = 8'b01100110;
            4'd5:    pat = 8'b01101101;
            4'd6:    pat = 8'b01111101;
            4'd7:    pat = 8'b00000111;
            4'd8:    pat = 8'b01111111;
            4'd9:    pat = 8'b01101111;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

>>> hdl/ssd_collect.sv
// ---------------------------------------------------------------------------
// ssd_collect
// Filters digits, keeps the digit group and registers one job per digit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssd_collect (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_char,
    input  ssd_pkg::ssd_cfg_t cfg,
    output logic              job_valid,
    output ssd_pkg::ssd_job_t job,
    input  logic              job_take
);

    logic [3:0]        digit_store [4];
    logic [1:0]        digit_count_reg, digit_count_next;
    logic              job_valid_reg, job_valid_next;
    ssd_pkg::ssd_job_t job_reg, job_next;
    logic              is_digit;
    logic              accept;
    logic              load;

    assign is_digit = (s_rx_char >= ssd_pkg::DIGIT_ZERO) && (s_rx_char <= ssd_pkg::DIGIT_NINE);
    assign s_ready  = !job_valid_reg || job_take;
    assign accept   = s_valid && s_ready;
    assign load     = accept && is_digit;

    always_comb begin
        digit_count_next = digit_count_reg;
        job_valid_next   = job_valid_reg;
        job_next         = job_reg;
        if (load) begin
            digit_count_next = digit_count_reg + 2'd1;
            job_valid_next   = 1'b1;
            job_next.echo    = s_rx_char;
            job_next.burst   = (digit_count_reg == 2'd3);
            job_next.digits  = {s_rx_char[3:0], digit_store[2], digit_store[1],
                                digit_store[0]};
            job_next.ctrl    = ssd_pkg::CMD_CTRL | {4'b0000, cfg.display_enable,
                                                    cfg.brightness};
        end else if (job_take) begin
            job_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= 2'd0;
            job_valid_reg   <= 1'b0;
        end else begin
            digit_count_reg <= digit_count_next;
            job_valid_reg   <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (load) begin
            digit_store[digit_count_reg] <= s_rx_char[3:0];
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    `SSD_ASSERT_NEXT(a_digit_makes_job, load, job_valid_reg, "accepted digit left no job")
    `SSD_ASSERT_NEXT(a_non_digit_keeps_count, accept && !is_digit,
                     digit_count_reg == $past(digit_count_reg), "non-digit changed the count")

endmodule

>>> hdl/ssd_emit.sv
// ---------------------------------------------------------------------------
// ssd_emit
// Walks one job through its result slots into the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssd_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    input  ssd_pkg::ssd_job_t job,
    output logic              job_take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [7:0]        m_data_byte,
    output logic              m_frame_start,
    output logic              m_frame_stop,
    output logic              m_last
);

    ssd_pkg::ssd_job_t    cur_reg, cur_next;
    logic                 busy_reg, busy_next;
    logic [2:0]           idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    ssd_pkg::ssd_result_t res_reg, res_next;
    ssd_pkg::ssd_result_t slot;
    logic                 out_free;
    logic                 step;
    logic                 final_slot;

    assign out_free   = !m_valid_reg || m_ready;
    assign step       = busy_reg && out_free;
    assign final_slot = !cur_reg.burst || (idx_reg == ssd_pkg::SLOT_CTRL);
    assign job_take   = !busy_reg || (step && final_slot);

    always_comb begin
        slot = '{kind: ssd_pkg::KIND_DISPLAY, data_byte: 8'h00,
                 frame_start: 1'b0, frame_stop: 1'b0, last: 1'b0};
        case (idx_reg)
            ssd_pkg::SLOT_ECHO: begin
                slot.kind      = ssd_pkg::KIND_ECHO;
                slot.data_byte = cur_reg.echo;
                slot.last      = !cur_reg.burst;
            end
            ssd_pkg::SLOT_DATA: begin
                slot.data_byte   = ssd_pkg::CMD_DATA;
                slot.frame_start = 1'b1;
                slot.frame_stop  = 1'b1;
            end
            ssd_pkg::SLOT_ADDR: begin
                slot.data_byte   = ssd_pkg::CMD_ADDR;
                slot.frame_start = 1'b1;
            end
            ssd_pkg::SLOT_SEG0: slot.data_byte = ssd_pkg::seg_pattern(cur_reg.digits[0]);
            ssd_pkg::SLOT_SEG1: slot.data_byte = ssd_pkg::seg_pattern(cur_reg.digits[1]);
            ssd_pkg::SLOT_SEG2: slot.data_byte = ssd_pkg::seg_pattern(cur_reg.digits[2]);
            ssd_pkg::SLOT_SEG3: begin
                slot.data_byte  = ssd_pkg::seg_pattern(cur_reg.digits[3]);
                slot.frame_stop = 1'b1;
            end
            ssd_pkg::SLOT_CTRL: begin
                slot.data_byte   = cur_reg.ctrl;
                slot.frame_start = 1'b1;
                slot.frame_stop  = 1'b1;
                slot.last        = 1'b1;
            end
            default: slot.data_byte = 8'h00;
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (step) begin
            idx_next = idx_reg + 3'd1;
        end
        if (job_take) begin
            busy_next = job_valid;
            cur_next  = job;
            idx_next  = ssd_pkg::SLOT_ECHO;
        end
        if (out_free) begin
            m_valid_next = step;
            res_next     = slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= ssd_pkg::SLOT_ECHO;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = res_reg.kind;
    assign m_data_byte   = res_reg.data_byte;
    assign m_frame_start = res_reg.frame_start;
    assign m_frame_stop  = res_reg.frame_stop;
    assign m_last        = res_reg.last;

    `SSD_ASSERT(a_slot_only_in_burst, (idx_reg == ssd_pkg::SLOT_ECHO) || (busy_reg && cur_reg.burst),
                "slot index moved outside a burst")
    `SSD_ASSERT(a_echo_is_digit, !(m_valid_reg && (m_kind == ssd_pkg::KIND_ECHO)) ||
                ((m_data_byte >= ssd_pkg::DIGIT_ZERO) && (m_data_byte <= ssd_pkg::DIGIT_NINE)),
                "echo result is not a digit")
    `SSD_ASSERT_NEXT(a_final_slot_marks_last, step && final_slot, m_valid_reg && m_last,
                     "final slot did not mark last")

endmodule

>>> hdl/serial_digits_to_segment_display.sv
// ---------------------------------------------------------------------------
// serial_digits_to_segment_display
// Collects serial digits, echoes each one and, on every fourth digit,
// emits the framed display bus command sequence.
// ---------------------------------------------------------------------------
//  channel  | direction | ports
//  s_       | in        | s_valid, s_ready, s_rx_char
//  m_       | out       | m_valid, m_ready, m_kind, m_data_byte, m_frame_start,
//           |           | m_frame_stop, m_last
//  cfg_     | in        | cfg_wr_en, cfg_addr, cfg_wr_data
//
// A digit gives one result, the fourth digit of a group eight; one result
// leaves per cycle while m_ready is high, set by the slot counter in the emitter.
// Non-digits are taken and give nothing.
// Results pass through the job, current-job and output registers.
// Reset clears the digit count and both valids; brightness resets to 7,
// the display enable to 1.
// m_ready low holds the output register, then the job, then s_ready.
// ---------------------------------------------------------------------------
module serial_digits_to_segment_display (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_data_byte,
    output logic       m_frame_start,
    output logic       m_frame_stop,
    output logic       m_last,
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [2:0] cfg_wr_data
);

    ssd_pkg::ssd_cfg_t cfg_reg, cfg_next;
    ssd_pkg::ssd_job_t job;
    logic              job_valid;
    logic              job_take;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                ssd_pkg::CFG_BRIGHTNESS:     cfg_next.brightness     = cfg_wr_data;
                ssd_pkg::CFG_DISPLAY_ENABLE: cfg_next.display_enable = cfg_wr_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{brightness: ssd_pkg::BRIGHTNESS_RESET,
                         display_enable: ssd_pkg::ENABLE_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ssd_collect u_collect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_char (s_rx_char),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    ssd_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (job_valid),
        .job           (job),
        .job_take      (job_take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_frame_start (m_frame_start),
        .m_frame_stop  (m_frame_stop),
        .m_last        (m_last)
    );

endmodule

>>> bench/tb_serial_digits_to_segment_display.sv
// ---------------------------------------------------------------------------
// tb_serial_digits_to_segment_display
// Feeds serial characters into the digit collector and checks every echo
// and display bus byte against a predictor of the digit store, the group
// count and the control byte. A short directed table comes first, then
// random characters, mostly digits, over several brightness and enable
// settings, with random idle gaps on both channels.
// ---------------------------------------------------------------------------
module tb_serial_digits_to_segment_display;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT           = 400_000;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int SETTLE          = 6;
    localparam int TAIL            = 20;
    localparam int SENDER          = 0;
    localparam int RECEIVER        = 1;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_ECHO,
        ROW_IGNORED
    } row_form_t;

    typedef struct packed {
        row_form_t            form;
        logic [7:0]           ch;
        ssd_pkg::ssd_result_t want;
    } probe_t;

    localparam logic [7:0] GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    function automatic probe_t echo_row(logic [7:0] ch);
        return '{ROW_ECHO, ch, '{ssd_pkg::KIND_ECHO, ch, 1'b0, 1'b0, 1'b1}};
    endfunction

    function automatic probe_t ignored_row(logic [7:0] ch);
        return '{ROW_IGNORED, ch, '0};
    endfunction

    function automatic probe_t predicted_row(logic [7:0] ch);
        return '{ROW_PREDICTED, ch, '0};
    endfunction

    localparam int NPROBES = 24;
    localparam probe_t PROBES [NPROBES] = '{
        echo_row(8'h30), ignored_row(8'h00), echo_row(8'h39), ignored_row(8'hFF),
        ignored_row(8'h2F), ignored_row(8'h3A), echo_row(8'h35), predicted_row(8'h37),
        predicted_row(8'h31), predicted_row(8'h32), predicted_row(8'h33),
        predicted_row(8'h34), ignored_row(8'hB5), predicted_row(8'h36),
        predicted_row(8'h38), ignored_row(8'h7F), predicted_row(8'h38),
        predicted_row(8'h36), ignored_row(8'h20), predicted_row(8'h39),
        predicted_row(8'h30), ignored_row(8'hC0), predicted_row(8'h35),
        predicted_row(8'h37)
    };

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_char;
    logic       m_valid;
    logic       m_ready;
    logic       m_kind;
    logic [7:0] m_data_byte;
    logic       m_frame_start;
    logic       m_frame_stop;
    logic       m_last;
    logic       cfg_wr_en;
    logic       cfg_addr;
    logic [2:0] cfg_wr_data;

    serial_digits_to_segment_display dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_char     (s_rx_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_frame_start (m_frame_start),
        .m_frame_stop  (m_frame_stop),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [3:0]           held_digits [4];
    int                   held_count;
    logic [2:0]           cur_brightness;
    logic                 cur_enable;
    ssd_pkg::ssd_result_t fresh_out [8];
    ssd_pkg::ssd_result_t owed_bytes [$];
    int                   errors;
    int                   cycles;
    int                   calm [2];

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic flag(string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic int draw_wait(int side);
        if (calm[side] > 0) begin
            calm[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm[side] = $urandom_range(8, 40);
        return $urandom_range(0, 17);
    endfunction

    function automatic void put_bus(int k, logic [7:0] data, logic fs, logic fe, logic lst);
        fresh_out[k] = '{ssd_pkg::KIND_DISPLAY, data, fs, fe, lst};
    endfunction

    // fill fresh_out with the transactions one character causes, return their number
    function automatic int absorb_char(logic [7:0] ch);
        logic [7:0] ctrl;
        if (ch < ssd_pkg::DIGIT_ZERO || ch > ssd_pkg::DIGIT_NINE)
            return 0;
        held_digits[held_count] = ch[3:0];
        held_count++;
        fresh_out[0] = '{ssd_pkg::KIND_ECHO, ch, 1'b0, 1'b0, held_count != 4};
        if (held_count != 4)
            return 1;
        held_count = 0;
        ctrl = ssd_pkg::CMD_CTRL | {4'b0000, cur_enable, cur_brightness};
        put_bus(1, ssd_pkg::CMD_DATA, 1'b1, 1'b1, 1'b0);
        put_bus(2, ssd_pkg::CMD_ADDR, 1'b1, 1'b0, 1'b0);
        put_bus(3, GLYPH[held_digits[0]], 1'b0, 1'b0, 1'b0);
        put_bus(4, GLYPH[held_digits[1]], 1'b0, 1'b0, 1'b0);
        put_bus(5, GLYPH[held_digits[2]], 1'b0, 1'b0, 1'b0);
        put_bus(6, GLYPH[held_digits[3]], 1'b0, 1'b1, 1'b0);
        put_bus(7, ctrl, 1'b1, 1'b1, 1'b1);
        return 8;
    endfunction

    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] digit;
        r = $urandom_range(0, 19);
        digit = ssd_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9));
        if (r < 14)
            return digit;
        if (r < 17)
            return 8'($urandom_range(0, 255));
        if (r == 17)
            return ($urandom_range(0, 1) != 0) ? 8'h2F : 8'h3A;
        return digit ^ (8'h01 << $urandom_range(4, 7));
    endfunction

    task automatic offer_char(logic [7:0] ch);
        int gap;
        gap = draw_wait(SENDER);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_char <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic feed(logic [7:0] ch);
        int n;
        offer_char(ch);
        n = absorb_char(ch);
        for (int k = 0; k < n; k++)
            owed_bytes.push_back(fresh_out[k]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (owed_bytes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic settle_and_configure(logic [2:0] br, logic en);
        drain();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= ssd_pkg::CFG_BRIGHTNESS;
        cfg_wr_data <= br;
        @(posedge aclk);
        cfg_addr    <= ssd_pkg::CFG_DISPLAY_ENABLE;
        cfg_wr_data <= {2'($urandom_range(0, 3)), en};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_brightness = br;
        cur_enable     = en;
    endtask

    initial begin
        ssd_pkg::ssd_result_t got;
        ssd_pkg::ssd_result_t want;
        int                   stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_wait(RECEIVER);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_kind, m_data_byte, m_frame_start, m_frame_stop, m_last};
            if (owed_bytes.size() == 0) begin
                flag($sformatf("unexpected transaction kind %0d byte %02h",
                               got.kind, got.data_byte));
            end else begin
                want = owed_bytes.pop_front();
                if (got.kind !== want.kind)
                    flag($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.data_byte !== want.data_byte)
                    flag($sformatf("data_byte %02h, want %02h",
                                   got.data_byte, want.data_byte));
                if (got.frame_start !== want.frame_start)
                    flag($sformatf("frame_start %0d, want %0d",
                                   got.frame_start, want.frame_start));
                if (got.frame_stop !== want.frame_stop)
                    flag($sformatf("frame_stop %0d, want %0d",
                                   got.frame_stop, want.frame_stop));
                if (got.last !== want.last)
                    flag($sformatf("last %0d, want %0d", got.last, want.last));
            end
        end
    end

    initial begin
        int         n;
        logic [2:0] br;
        logic       en;
        errors         = 0;
        cycles         = 0;
        held_count     = 0;
        calm           = '{0, 0};
        cur_brightness = ssd_pkg::BRIGHTNESS_RESET;
        cur_enable     = ssd_pkg::ENABLE_RESET;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_rx_char   <= 8'h00;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= ssd_pkg::CFG_BRIGHTNESS;
        cfg_wr_data <= 3'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                for (int i = 0; i < NPROBES; i++) begin
                    offer_char(PROBES[i].ch);
                    n = absorb_char(PROBES[i].ch);
                    case (PROBES[i].form)
                        ROW_ECHO: owed_bytes.push_back(PROBES[i].want);
                        ROW_IGNORED: ;
                        default: begin
                            for (int k = 0; k < n; k++)
                                owed_bytes.push_back(fresh_out[k]);
                        end
                    endcase
                end
            end else begin
                case (ph)
                    1: {br, en} = {3'd0, 1'b0};
                    2: {br, en} = {3'd7, 1'b0};
                    3: {br, en} = {3'd0, 1'b1};
                    PHASES - 1: {br, en} = {3'd7, 1'b1};
                    default: {br, en} = 4'($urandom_range(0, 15));
                endcase
                settle_and_configure(br, en);
            end
            repeat (ITEMS_PER_PHASE) feed(pick_char());
        end

        drain();
        repeat (TAIL) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ssd_pkg.sv
hdl/ssd_collect.sv
hdl/ssd_emit.sv
hdl/serial_digits_to_segment_display.sv
bench/tb_serial_digits_to_segment_display.sv
